[rtl/snps_pkg.sv]
// Shared types, codes and constants of the sensor node poll scheduler.
`default_nettype none

package snps_pkg;

    // Default table depth.
    localparam int MAX_NODES_DEF = 8;

    // Register reset values.
    localparam logic [31:0] RST_REPLY_TIMEOUT = 32'd1000;
    localparam logic [15:0] RST_RADIO_PERIOD  = 16'd100;

    // Stream widths.
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;

    // APB address width and register indexes (taken from paddr[2]).
    localparam int ADDR_W = 3;
    localparam logic REG_REPLY_TIMEOUT = 1'b0;
    localparam logic REG_RADIO_PERIOD  = 1'b1;

    // Item mode codes.
    localparam logic MODE_HEARTBEAT = 1'b0;
    localparam logic MODE_REGISTER  = 1'b1;

    // Received message kinds.
    localparam logic [1:0] KIND_OTHER    = 2'd0;
    localparam logic [1:0] KIND_UPDATE   = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_DUE,
        ST_TIMEOUT,
        ST_RADIO,
        ST_SCAN_ID,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic do_register;
        logic scan_next;
        logic scan_restart;
        logic start_poll;
        logic do_timeout;
        logic do_radio;
        logic reschedule;
        logic load_result;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_register;
        logic poll_idle;
        logic scan_end;
        logic due_hit;
        logic id_hit;
        logic finish_pending;
        logic out_free;
        logic reply_pending;
        logic active_valid;
    } stat_t;

endpackage

`default_nettype wire

[rtl/snps_ctrl.sv]
// Controller state machine of the sensor node poll scheduler.
`default_nettype none

module snps_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire snps_pkg::stat_t stat,
    output snps_pkg::cmd_t      cmd
);
    import snps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (stat.is_register)
                begin
                    cmd.do_register = 1'b1;
                    state_next      = ST_DONE;
                end
                else if (stat.poll_idle)
                begin
                    state_next = ST_SCAN_DUE;
                end
                else
                begin
                    state_next = ST_TIMEOUT;
                end
            end
            ST_SCAN_DUE:
            begin
                priority if (stat.scan_end)
                begin
                    state_next = ST_TIMEOUT;
                end
                else if (stat.due_hit)
                begin
                    cmd.start_poll = 1'b1;
                    state_next     = ST_TIMEOUT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_TIMEOUT:
            begin
                cmd.do_timeout = 1'b1;
                state_next     = ST_RADIO;
            end
            ST_RADIO:
            begin
                cmd.do_radio     = 1'b1;
                cmd.scan_restart = 1'b1;
                state_next       = ST_SCAN_ID;
            end
            ST_SCAN_ID:
            begin
                priority if (!stat.finish_pending || stat.scan_end)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.id_hit)
                begin
                    cmd.reschedule = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/snps_dpath.sv]
// Datapath of the sensor node poll scheduler: node table, poll state and result register.
`default_nettype none

module snps_dpath #(
    parameter int MAX_NODES = snps_pkg::MAX_NODES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire snps_pkg::cmd_t                  cmd,
    output snps_pkg::stat_t                      stat,
    input  wire logic                            s_tuser,
    input  wire logic [snps_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [snps_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic [31:0]                     reply_timeout_ms,
    input  wire logic [15:0]                     radio_period_ms
);
    import snps_pkg::*;

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    // Node table.
    logic [7:0]  node_ids       [MAX_NODES];
    logic [31:0] node_intervals [MAX_NODES];
    logic [31:0] node_due_times [MAX_NODES];

    // Captured item.
    logic        mode_reg, mode_next;
    logic [31:0] now_reg, now_next;
    logic [7:0]  id_reg, id_next;
    logic [31:0] interval_reg, interval_next;
    logic        rx_valid_reg, rx_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic        can_send_reg, can_send_next;

    // Scheduler state.
    logic [CNT_W-1:0] nodes_used_reg, nodes_used_next;
    logic [7:0]       active_node_reg, active_node_next;
    logic             active_valid_reg, active_valid_next;
    logic             send_pending_reg, send_pending_next;
    logic             reply_pending_reg, reply_pending_next;
    logic [31:0]      reply_deadline_reg, reply_deadline_next;
    logic [31:0]      next_radio_reg, next_radio_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             fin_reg, fin_next;

    // Result being built and the output register.
    logic       r_send_reg, r_send_next;
    logic [7:0] r_send_node_reg, r_send_node_next;
    logic       r_timed_out_reg, r_timed_out_next;
    logic       r_deliv_reg, r_deliv_next;
    logic [1:0] r_kind_reg, r_kind_next;
    logic       r_ended_reg, r_ended_next;
    logic [7:0] r_ended_node_reg, r_ended_node_next;
    logic       r_full_reg, r_full_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic [IDX_W-1:0] scan_idx;
    logic [IDX_W-1:0] fill_idx;
    logic             table_full;
    logic [31:0]      timeout_sum;
    logic [31:0]      radio_sum;
    logic [1:0]       in_kind;

    assign scan_idx    = idx_reg[IDX_W-1:0];
    assign fill_idx    = nodes_used_reg[IDX_W-1:0];
    assign table_full  = (nodes_used_reg == CNT_W'(MAX_NODES));
    assign timeout_sum = now_reg + reply_timeout_ms;
    assign radio_sum   = now_reg + {16'd0, radio_period_ms};
    assign in_kind     = s_tdata[74:73];

    always_comb
    begin
        stat                = '0;
        stat.is_register    = (mode_reg == MODE_REGISTER);
        stat.poll_idle      = !send_pending_reg && !reply_pending_reg;
        stat.scan_end       = (idx_reg >= nodes_used_reg);
        stat.due_hit        = (node_due_times[scan_idx] <= now_reg);
        stat.id_hit         = (node_ids[scan_idx] == active_node_reg);
        stat.finish_pending = fin_reg;
        stat.out_free       = !m_valid_reg || m_tready;
        stat.reply_pending  = reply_pending_reg;
        stat.active_valid   = active_valid_reg;
    end

    always_comb
    begin
        mode_next           = mode_reg;
        now_next            = now_reg;
        id_next             = id_reg;
        interval_next       = interval_reg;
        rx_valid_next       = rx_valid_reg;
        kind_next           = kind_reg;
        can_send_next       = can_send_reg;
        nodes_used_next     = nodes_used_reg;
        active_node_next    = active_node_reg;
        active_valid_next   = active_valid_reg;
        send_pending_next   = send_pending_reg;
        reply_pending_next  = reply_pending_reg;
        reply_deadline_next = reply_deadline_reg;
        next_radio_next     = next_radio_reg;
        idx_next            = idx_reg;
        fin_next            = fin_reg;
        r_send_next         = r_send_reg;
        r_send_node_next    = r_send_node_reg;
        r_timed_out_next    = r_timed_out_reg;
        r_deliv_next        = r_deliv_reg;
        r_kind_next         = r_kind_reg;
        r_ended_next        = r_ended_reg;
        r_ended_node_next   = r_ended_node_reg;
        r_full_next         = r_full_reg;
        m_valid_next        = m_valid_reg;
        m_data_next         = m_data_reg;

        if (cmd.capture)
        begin
            mode_next         = s_tuser;
            now_next          = s_tdata[31:0];
            id_next           = s_tdata[39:32];
            interval_next     = s_tdata[71:40];
            rx_valid_next     = s_tdata[72];
            // The reserved kind is handled and delivered as other.
            kind_next         = (in_kind == KIND_RESERVED) ? KIND_OTHER : in_kind;
            can_send_next     = s_tdata[75];
            idx_next          = '0;
            fin_next          = 1'b0;
            r_send_next       = 1'b0;
            r_send_node_next  = '0;
            r_timed_out_next  = 1'b0;
            r_deliv_next      = 1'b0;
            r_kind_next       = KIND_OTHER;
            r_ended_next      = 1'b0;
            r_ended_node_next = '0;
            r_full_next       = 1'b0;
        end

        if (cmd.do_register)
        begin
            if (table_full)
            begin
                r_full_next = 1'b1;
            end
            else
            begin
                nodes_used_next = nodes_used_reg + CNT_W'(1);
            end
        end

        if (cmd.scan_next)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (cmd.scan_restart)
        begin
            idx_next = '0;
        end

        if (cmd.start_poll)
        begin
            active_node_next    = node_ids[scan_idx];
            active_valid_next   = 1'b1;
            reply_pending_next  = 1'b1;
            send_pending_next   = 1'b1;
            reply_deadline_next = timeout_sum;
        end

        if (cmd.do_timeout && reply_pending_reg && (reply_deadline_reg <= now_reg))
        begin
            if (active_valid_reg)
            begin
                r_ended_next      = 1'b1;
                r_ended_node_next = active_node_reg;
                fin_next          = 1'b1;
                active_valid_next = 1'b0;
            end
            reply_pending_next = 1'b0;
            r_timed_out_next   = 1'b1;
        end

        if (cmd.do_radio && (next_radio_reg <= now_reg))
        begin
            if (rx_valid_reg)
            begin
                if (kind_reg == KIND_UPDATE)
                begin
                    reply_deadline_next = timeout_sum;
                end
                // A completion with no active poll is delivered but ends nothing.
                if (kind_reg == KIND_COMPLETE && active_valid_reg)
                begin
                    r_ended_next       = 1'b1;
                    r_ended_node_next  = active_node_reg;
                    fin_next           = 1'b1;
                    active_valid_next  = 1'b0;
                    reply_pending_next = 1'b0;
                end
                r_deliv_next = 1'b1;
                r_kind_next  = kind_reg;
            end
            if (send_pending_reg && can_send_reg)
            begin
                r_send_next       = 1'b1;
                r_send_node_next  = active_node_reg;
                send_pending_next = 1'b0;
            end
            next_radio_next = radio_sum;
        end

        if (cmd.reschedule)
        begin
            fin_next = 1'b0;
        end

        if (cmd.load_result)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, r_full_reg, r_ended_node_reg, r_ended_reg, r_kind_reg,
                            r_deliv_reg, r_timed_out_reg, r_send_node_reg, r_send_reg};
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_used_reg     <= '0;
            active_node_reg    <= '0;
            active_valid_reg   <= 1'b0;
            send_pending_reg   <= 1'b0;
            reply_pending_reg  <= 1'b0;
            reply_deadline_reg <= '0;
            next_radio_reg     <= '0;
            idx_reg            <= '0;
            fin_reg            <= 1'b0;
            mode_reg           <= MODE_HEARTBEAT;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            nodes_used_reg     <= nodes_used_next;
            active_node_reg    <= active_node_next;
            active_valid_reg   <= active_valid_next;
            send_pending_reg   <= send_pending_next;
            reply_pending_reg  <= reply_pending_next;
            reply_deadline_reg <= reply_deadline_next;
            next_radio_reg     <= next_radio_next;
            idx_reg            <= idx_next;
            fin_reg            <= fin_next;
            mode_reg           <= mode_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg          <= now_next;
        id_reg           <= id_next;
        interval_reg     <= interval_next;
        rx_valid_reg     <= rx_valid_next;
        kind_reg         <= kind_next;
        can_send_reg     <= can_send_next;
        r_send_reg       <= r_send_next;
        r_send_node_reg  <= r_send_node_next;
        r_timed_out_reg  <= r_timed_out_next;
        r_deliv_reg      <= r_deliv_next;
        r_kind_reg       <= r_kind_next;
        r_ended_reg      <= r_ended_next;
        r_ended_node_reg <= r_ended_node_next;
        r_full_reg       <= r_full_next;
        m_data_reg       <= m_data_next;
    end

    // Table writes: a new entry at the fill point, or a reschedule at the scan point.
    always_ff @(posedge clk)
    begin
        if (cmd.do_register && !table_full)
        begin
            node_ids[fill_idx]       <= id_reg;
            node_intervals[fill_idx] <= interval_reg;
            node_due_times[fill_idx] <= now_reg + interval_reg;
        end
        if (cmd.reschedule)
        begin
            node_due_times[scan_idx] <= now_reg + node_intervals[scan_idx];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

[rtl/sensor_node_poll_scheduler_top.sv]
// Top level of the sensor node poll scheduler: APB registers, controller and datapath.
`default_nettype none

// Steps: a registration word passes decode and done; a heartbeat word passes decode,
// the due-time scan (when no poll is pending), timeout check, radio service, reschedule
// scan and done; the two table scans each visit one table entry per cycle.
// Throughput: one word at a time; the next input word is taken as soon as the result of
// the previous one sits in the output register, even if that result is not yet taken.
// Reset: rst_n clears the table fill count, the poll state and the radio timer, and sets
// the reply timeout to 1000 ms and the radio period to 100 ms; table entries are not cleared.
module sensor_node_poll_scheduler_top #(
    parameter int MAX_NODES = snps_pkg::MAX_NODES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata from bit 0 up: time_ms[31:0], node_id[39:32], interval_ms[71:40],
    // rx_valid[72], rx_kind[74:73], radio_can_send[75], zero fill[79:76].
    input  wire logic [snps_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser: mode (0 heartbeat, 1 register node).
    input  wire logic                            s_tuser,
    // Output stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata from bit 0 up: send_valid[0], send_node[8:1], timed_out[9], rx_delivered[10],
    // delivered_kind[12:11], poll_ended[13], ended_node[21:14], table_full[22], zero[23].
    output logic [snps_pkg::OUT_DATA_W-1:0]      m_tdata,
    // APB register port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [snps_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import snps_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    logic [31:0] reply_timeout_reg;
    logic [15:0] radio_period_reg;
    logic        cfg_write;
    logic        cfg_sel;

    // Registers are selected by address bit 2: the reply timeout at 0, the radio period at 4.
    assign pready    = 1'b1;
    assign cfg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_timeout_reg <= RST_REPLY_TIMEOUT;
            radio_period_reg  <= RST_RADIO_PERIOD;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_REPLY_TIMEOUT: reply_timeout_reg <= pwdata;
                REG_RADIO_PERIOD:  radio_period_reg  <= pwdata[15:0];
                default:           reply_timeout_reg <= reply_timeout_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_REPLY_TIMEOUT: prdata = reply_timeout_reg;
            REG_RADIO_PERIOD:  prdata = {16'd0, radio_period_reg};
            default:           prdata = '0;
        endcase
    end

    // The controller steps through decode, due-time scan, timeout check, radio service
    // and reschedule scan; the datapath holds the table and applies each step.
    snps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    snps_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .s_tuser          (s_tuser),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .reply_timeout_ms (reply_timeout_reg),
        .radio_period_ms  (radio_period_reg)
    );

    // A pending reply always belongs to an active poll.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.reply_pending |-> stat.active_valid)
    else $error("reply pending without an active poll");

    // Only one word is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while one is in work");

    // A refused registration reports nothing else.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[22]) |-> (m_tdata[21:0] == 22'd0))
    else $error("table full result carries other fields");

endmodule

`default_nettype wire

[tb/sv/poll_sched_tb_pkg.sv]
// Word layouts, behavioral predictor and scoreboard for the poll scheduler testbench.
`timescale 1ns / 100ps

package poll_sched_tb_pkg;

    import snps_pkg::*;

    // Input word as it travels on s_tdata, most significant field first.
    typedef struct packed {
        logic [3:0]  zero_fill;
        logic        radio_can_send;
        logic [1:0]  rx_kind;
        logic        rx_valid;
        logic [31:0] interval_ms;
        logic [7:0]  node_id;
        logic [31:0] time_ms;
    } poll_word_t;

    // Result word as it travels on m_tdata, most significant field first.
    typedef struct packed {
        logic        zero_fill;
        logic        table_full;
        logic [7:0]  ended_node;
        logic        poll_ended;
        logic [1:0]  delivered_kind;
        logic        rx_delivered;
        logic        timed_out;
        logic [7:0]  send_node;
        logic        send_valid;
    } poll_report_t;

    class poll_scoreboard;

        logic [7:0]   node_id_tab [MAX_NODES_DEF];
        logic [31:0]  interval_tab [MAX_NODES_DEF];
        logic [31:0]  due_tab [MAX_NODES_DEF];
        int unsigned  nodes_used;
        logic [7:0]   active_node;
        logic         active_valid;
        logic         send_pending;
        logic         reply_pending;
        logic [31:0]  reply_deadline;
        logic [31:0]  next_radio_ms;
        logic [31:0]  reply_timeout_ms;
        logic [15:0]  radio_period_ms;
        poll_report_t expected_reports [$];
        int unsigned  mismatches;

        function new();
            nodes_used       = 0;
            active_node      = '0;
            active_valid     = 1'b0;
            send_pending     = 1'b0;
            reply_pending    = 1'b0;
            reply_deadline   = '0;
            next_radio_ms    = '0;
            reply_timeout_ms = RST_REPLY_TIMEOUT;
            radio_period_ms  = RST_RADIO_PERIOD;
            mismatches       = 0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == REG_REPLY_TIMEOUT)
                reply_timeout_ms = value;
            else
                radio_period_ms = value[15:0];
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // Closes the active poll and moves the first table entry with its id forward.
        function void end_poll(logic [31:0] now);
            if (!active_valid)
                return;
            for (int i = 0; i < nodes_used; i++)
            begin
                if (node_id_tab[i] == active_node)
                begin
                    due_tab[i] = now + interval_tab[i];
                    break;
                end
            end
            active_valid  = 1'b0;
            reply_pending = 1'b0;
        endfunction

        // Advances the predicted state by one accepted word and queues its report.
        function void note_word(logic mode, poll_word_t w);
            poll_report_t r;
            logic [1:0]   kind;
            logic [31:0]  now;
            r    = '0;
            now  = w.time_ms;
            kind = (w.rx_kind == KIND_RESERVED) ? KIND_OTHER : w.rx_kind;
            if (mode == MODE_REGISTER)
            begin
                if (nodes_used >= MAX_NODES_DEF)
                    r.table_full = 1'b1;
                else
                begin
                    node_id_tab[nodes_used]  = w.node_id;
                    interval_tab[nodes_used] = w.interval_ms;
                    due_tab[nodes_used]      = now + w.interval_ms;
                    nodes_used++;
                end
            end
            else
            begin
                if (!send_pending && !reply_pending)
                begin
                    for (int i = 0; i < nodes_used; i++)
                    begin
                        if (due_tab[i] <= now)
                        begin
                            active_node    = node_id_tab[i];
                            active_valid   = 1'b1;
                            reply_pending  = 1'b1;
                            reply_deadline = now + reply_timeout_ms;
                            send_pending   = 1'b1;
                            break;
                        end
                    end
                end
                if (reply_pending && reply_deadline <= now)
                begin
                    if (active_valid)
                    begin
                        r.poll_ended = 1'b1;
                        r.ended_node = active_node;
                        end_poll(now);
                    end
                    reply_pending = 1'b0;
                    r.timed_out   = 1'b1;
                end
                if (next_radio_ms <= now)
                begin
                    if (w.rx_valid)
                    begin
                        if (kind == KIND_UPDATE)
                            reply_deadline = now + reply_timeout_ms;
                        else if (kind == KIND_COMPLETE && active_valid)
                        begin
                            r.poll_ended = 1'b1;
                            r.ended_node = active_node;
                            end_poll(now);
                        end
                        r.rx_delivered   = 1'b1;
                        r.delivered_kind = kind;
                    end
                    if (send_pending && w.radio_can_send)
                    begin
                        r.send_valid = 1'b1;
                        r.send_node  = active_node;
                        send_pending = 1'b0;
                    end
                    next_radio_ms = now + {16'd0, radio_period_ms};
                end
            end
            expected_reports.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
            if (got_val !== exp_val)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, got_val);
                mismatches++;
            end
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] data);
            poll_report_t got;
            poll_report_t exp_r;
            got = data;
            if (expected_reports.size() == 0)
            begin
                $error("result word 0x%0h arrived with nothing outstanding", data);
                mismatches++;
                return;
            end
            exp_r = expected_reports.pop_front();
            check_field("send_valid", 32'(exp_r.send_valid), 32'(got.send_valid));
            check_field("send_node", 32'(exp_r.send_node), 32'(got.send_node));
            check_field("timed_out", 32'(exp_r.timed_out), 32'(got.timed_out));
            check_field("rx_delivered", 32'(exp_r.rx_delivered), 32'(got.rx_delivered));
            check_field("delivered_kind", 32'(exp_r.delivered_kind),
                        32'(got.delivered_kind));
            check_field("poll_ended", 32'(exp_r.poll_ended), 32'(got.poll_ended));
            check_field("ended_node", 32'(exp_r.ended_node), 32'(got.ended_node));
            check_field("table_full", 32'(exp_r.table_full), 32'(got.table_full));
            check_field("zero_fill", 32'(exp_r.zero_fill), 32'(got.zero_fill));
        endfunction

    endclass

endpackage

[tb/sv/sensor_node_poll_scheduler_top_tb.sv]
// Self-checking testbench for the sensor node poll scheduler top level.
`timescale 1ns / 100ps

module sensor_node_poll_scheduler_top_tb;

    import snps_pkg::*;
    import poll_sched_tb_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int NUM_ITEMS    = 1100;
    // Both registers are rewritten after this many words.
    localparam int CFG_EVERY    = 150;
    // The longest random stall on each side plus the worst heartbeat latency stays far below this.
    localparam int WATCHDOG_LIMIT = 400;
    // Cycles to keep watching after the last result, for a stray extra word.
    localparam int DRAIN_CYCLES = 2 * MAX_NODES_DEF + 4 + 8;

    // Register byte addresses.
    localparam logic [ADDR_W-1:0] ADDR_REPLY_TIMEOUT = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_RADIO_PERIOD  = 3'd4;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    poll_scoreboard sb;
    int unsigned    idle_cycles = 0;

    sensor_node_poll_scheduler_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Offers one word after a random idle time and returns at its accepting edge.
    task automatic send_word(input logic mode, input poll_word_t w);
        int unsigned gap;
        gap = $urandom_range(8);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Takes result words, idling a random number of cycles before each one.
    task automatic take_words();
        int unsigned gap;
        forever
        begin
            gap = $urandom_range(8);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    endtask

    // Returns at a rising edge once every accepted word has its result taken.
    task automatic wait_idle();
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, then back to idle.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_timeout();
        int unsigned roll;
        roll = $urandom_range(4);
        case (roll)
            0:       return 32'($urandom_range(5));
            1:       return 32'($urandom_range(400, 50));
            2:       return 32'd1000;
            3:       return 32'($urandom_range(3000, 500));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        int unsigned roll;
        roll = $urandom_range(3);
        case (roll)
            0:       return 32'($urandom_range(1));
            1:       return 32'($urandom_range(200, 10));
            2:       return 32'd100;
            default: return {$urandom_range(65535), 16'($urandom_range(150, 50))};
        endcase
    endfunction

    function automatic logic [31:0] pick_interval();
        int unsigned roll;
        roll = $urandom_range(7);
        case (roll)
            0:       return 32'($urandom_range(20));
            7:       return $urandom;
            default: return 32'($urandom_range(800, 50));
        endcase
    endfunction

    // Time mostly moves forward, with rare jumps and small steps back.
    function automatic logic [31:0] next_time(logic [31:0] t);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 2)
            return $urandom;
        else if (roll < 6)
            return t - 32'($urandom_range(50));
        else
            return t + 32'($urandom_range(120));
    endfunction

    // Every accepted word, result and register write is seen here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
            if (psel && penable && pwrite && pready)
                sb.set_register(paddr[2], pwdata);
        end
    end

    // Watchdog: counts cycles in which nothing is accepted on any port.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (psel && penable && pwrite && pready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $error("no word accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        poll_word_t  w;
        logic        mode;
        logic [31:0] now_ms;
        sb     = new();
        now_ms = 32'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            take_words();
        join_none
        for (int n = 0; n < NUM_ITEMS; n++)
        begin
            // Registers change only while no word is in work.
            if (n % CFG_EVERY == 0)
            begin
                s_tvalid <= 1'b0;
                wait_idle();
                write_reg(ADDR_REPLY_TIMEOUT, pick_timeout());
                write_reg(ADDR_RADIO_PERIOD, pick_period());
            end
            now_ms = next_time(now_ms);
            // Registrations are frequent early so the table fills and then overflows.
            if ((n < 40) ? ($urandom_range(2) == 0) : ($urandom_range(11) == 0))
                mode = MODE_REGISTER;
            else
                mode = MODE_HEARTBEAT;
            w                = '0;
            w.time_ms        = now_ms;
            w.node_id        = 8'($urandom_range(15));
            w.interval_ms    = pick_interval();
            w.rx_valid       = 1'($urandom_range(1));
            w.rx_kind        = 2'($urandom_range(3));
            w.radio_can_send = ($urandom_range(9) < 7);
            send_word(mode, w);
        end
        s_tvalid <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
rtl/snps_pkg.sv
rtl/snps_ctrl.sv
rtl/snps_dpath.sv
rtl/sensor_node_poll_scheduler_top.sv
tb/sv/poll_sched_tb_pkg.sv
tb/sv/sensor_node_poll_scheduler_top_tb.sv
